>>> design/cursor_overlay_alpha_blend_macros.svh
// ----------------------------------------------------------------------------
// Cursor overlay alpha blend - assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef CURSOR_OVERLAY_ALPHA_BLEND_MACROS_SVH
`define CURSOR_OVERLAY_ALPHA_BLEND_MACROS_SVH

// same-cycle implication, masked while rst is high
`define COAB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cursor overlay port check failed");

// next-cycle implication, masked while rst is high
`define COAB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cursor overlay port check failed");

`endif

>>> design/coab_pkg.sv
// ----------------------------------------------------------------------------
// coab_pkg
// Types and constants shared by the cursor overlay alpha blend modules.
// ----------------------------------------------------------------------------
package coab_pkg;

   // request beat operation codes
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_BLEND = 1'b1;

   // blend arithmetic constants
   localparam int unsigned ALPHA_SHIFT = 24;
   localparam logic [7:0]  FULL_ALPHA  = 8'd255;
   localparam logic [15:0] HALF_ROUND  = 16'(255 / 2);

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_POINTER_X    = 3'd0,
      CSR_POINTER_Y    = 3'd1,
      CSR_HOTSPOT_X    = 3'd2,
      CSR_HOTSPOT_Y    = 3'd3,
      CSR_CAPTURE_LEFT = 3'd4,
      CSR_CAPTURE_TOP  = 3'd5,
      CSR_CURSOR_COLS  = 3'd6,
      CSR_CURSOR_ROWS  = 3'd7
   } csr_index_type;

   // input beat
   typedef struct packed {
      logic        func;
      logic [11:0] cursor_addr;
      logic [12:0] col;
      logic [12:0] row;
      logic [31:0] pixel_in;
   } req_type;

   // result beat
   typedef struct packed {
      logic [31:0] pixel_out;
      logic        covered;
   } rsp_type;

   // cursor placement derived from the configuration registers
   typedef struct packed {
      logic [14:0] org_x;
      logic [14:0] org_y;
      logic [6:0]  cols;
      logic [6:0]  rows;
   } geom_type;

   // control and pixel carried along the pipeline
   typedef struct packed {
      logic        valid;
      logic        func;
      logic        hit;
      logic        in_store;
      logic [31:0] pixel;
   } stage_type;

endpackage

>>> design/cursor_overlay_alpha_blend.sv
// ----------------------------------------------------------------------------
// cursor_overlay_alpha_blend
// Hardware cursor overlay: cursor store loads and premultiplied alpha blend.
// ----------------------------------------------------------------------------
// A blend result passes registers a, b, read and result; a stall holds them.
// One beat per clock unless stalled; the memory stage does one access a beat.
// Each configuration write holds off requests for the following cycle while
// the cursor placement is recomputed.
// Reset clears the configuration registers and the pipeline valid bits; the
// cursor store is undefined until loaded and needs no clearing pass.
module cursor_overlay_alpha_blend #(
   parameter int MAX_CURSOR_DIM = 64,
   parameter int COORD_BITS     = 13
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  coab_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output coab_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   localparam int ADDR_W = $clog2(MAX_CURSOR_DIM * MAX_CURSOR_DIM);

   coab_pkg::geom_type  geom;
   coab_pkg::stage_type op_stage, rd_stage;
   logic [ADDR_W-1:0]   op_addr;
   logic [31:0]         rd_word;
   logic                cfg_busy, advance, req_take;

   // request side
   assign req_stall = !advance || cfg_busy;
   assign req_take  = req_valid && !req_stall;

   coab_csr #(
      .MAX_CURSOR_DIM (MAX_CURSOR_DIM)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .geom      (geom),
      .cfg_busy  (cfg_busy)
   );

   coab_locate #(
      .MAX_CURSOR_DIM (MAX_CURSOR_DIM),
      .COORD_BITS     (COORD_BITS)
   ) u_locate (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .req_take (req_take),
      .req_data (req_data),
      .geom     (geom),
      .op_stage (op_stage),
      .op_addr  (op_addr)
   );

   coab_store #(
      .MAX_CURSOR_DIM (MAX_CURSOR_DIM)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .op_stage (op_stage),
      .op_addr  (op_addr),
      .rd_stage (rd_stage),
      .rd_word  (rd_word)
   );

   coab_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .rd_stage  (rd_stage),
      .rd_word   (rd_word),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .advance   (advance)
   );

endmodule

>>> design/coab_csr.sv
// ----------------------------------------------------------------------------
// coab_csr
// Configuration registers and the registered cursor origin and size.
// ----------------------------------------------------------------------------
module coab_csr #(
   parameter int MAX_CURSOR_DIM = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_wdata,
   output coab_pkg::geom_type  geom,
   output logic                cfg_busy
);

   logic [15:0]        ptr_x_ff, ptr_y_ff;
   logic [5:0]         hot_x_ff, hot_y_ff;
   logic [12:0]        cap_left_ff, cap_top_ff;
   logic [6:0]         cols_ff, rows_ff;
   coab_pkg::geom_type geom_ff, geom_in;
   logic               busy_ff;

   // origin on one axis: two 16-bit wrapping subtracts, clamp at zero
   function automatic logic [14:0] origin(input logic [15:0] ptr,
                                          input logic [5:0]  hot,
                                          input logic [12:0] off);
      logic [15:0] a;
      logic [15:0] b;
      a = ptr - {10'd0, hot};
      b = a - {3'd0, off};
      return b[15] ? 15'd0 : b[14:0];
   endfunction

   // size limited to the store's row length
   function automatic logic [6:0] sat_dim(input logic [6:0] d);
      return (32'(d) > MAX_CURSOR_DIM) ? 7'(MAX_CURSOR_DIM) : d;
   endfunction

   assign csr_ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_x_ff    <= '0;
         ptr_y_ff    <= '0;
         hot_x_ff    <= '0;
         hot_y_ff    <= '0;
         cap_left_ff <= '0;
         cap_top_ff  <= '0;
         cols_ff     <= '0;
         rows_ff     <= '0;
      end else if (csr_valid) begin
         case (coab_pkg::csr_index_type'(csr_index))
            coab_pkg::CSR_POINTER_X:    ptr_x_ff    <= csr_wdata;
            coab_pkg::CSR_POINTER_Y:    ptr_y_ff    <= csr_wdata;
            coab_pkg::CSR_HOTSPOT_X:    hot_x_ff    <= csr_wdata[5:0];
            coab_pkg::CSR_HOTSPOT_Y:    hot_y_ff    <= csr_wdata[5:0];
            coab_pkg::CSR_CAPTURE_LEFT: cap_left_ff <= csr_wdata[12:0];
            coab_pkg::CSR_CAPTURE_TOP:  cap_top_ff  <= csr_wdata[12:0];
            coab_pkg::CSR_CURSOR_COLS:  cols_ff     <= csr_wdata[6:0];
            coab_pkg::CSR_CURSOR_ROWS:  rows_ff     <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // derived placement
   always_comb begin
      geom_in.org_x = origin(ptr_x_ff, hot_x_ff, cap_left_ff);
      geom_in.org_y = origin(ptr_y_ff, hot_y_ff, cap_top_ff);
      geom_in.cols  = sat_dim(cols_ff);
      geom_in.rows  = sat_dim(rows_ff);
   end

   // placement follows the registers in the next cycle; busy covers that cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         geom_ff <= geom_in;
         busy_ff <= csr_valid;
      end
   end

   assign geom     = geom_ff;
   assign cfg_busy = busy_ff;

endmodule

>>> design/coab_locate.sv
// ----------------------------------------------------------------------------
// coab_locate
// Rectangle test at accept, then the cursor store address for each beat.
// ----------------------------------------------------------------------------
module coab_locate #(
   parameter int MAX_CURSOR_DIM = 64,
   parameter int COORD_BITS     = 13,
   localparam int DEPTH  = MAX_CURSOR_DIM * MAX_CURSOR_DIM,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                req_take,
   input  coab_pkg::req_type   req_data,
   input  coab_pkg::geom_type  geom,
   output coab_pkg::stage_type op_stage,
   output logic [ADDR_W-1:0]   op_addr
);

   localparam int          DIM_W      = $clog2(MAX_CURSOR_DIM);
   localparam int          PROD_W     = DIM_W + 8;
   localparam logic [12:0] COORD_MASK = 13'((33'd1 << COORD_BITS) - 33'd1);

   logic [12:0]         col_m, row_m;
   logic [16:0]         diff_x, diff_y;
   logic                hit_x, hit_y;
   coab_pkg::stage_type a_in;
   coab_pkg::stage_type a_ff, b_ff;
   logic [DIM_W-1:0]    a_dx_ff, a_dy_ff;
   logic [ADDR_W-1:0]   a_addr_ff, b_addr_ff;
   logic [PROD_W-1:0]   idx_full;

   // rectangle test against the registered origin
   always_comb begin
      col_m  = req_data.col & COORD_MASK;
      row_m  = req_data.row & COORD_MASK;
      diff_x = {4'd0, col_m} - {2'd0, geom.org_x};
      diff_y = {4'd0, row_m} - {2'd0, geom.org_y};
      hit_x  = !diff_x[16] && (diff_x[15:0] < {9'd0, geom.cols});
      hit_y  = !diff_y[16] && (diff_y[15:0] < {9'd0, geom.rows});

      a_in.valid    = req_take;
      a_in.func     = req_data.func;
      a_in.hit      = hit_x && hit_y;
      a_in.in_store = 32'(req_data.cursor_addr) < DEPTH;
      a_in.pixel    = req_data.pixel_in;
   end

   // row-major cursor index
   assign idx_full = PROD_W'(a_dy_ff) * PROD_W'(geom.cols) + PROD_W'(a_dx_ff);

   // stage registers; only the valid bits take reset
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
         b_ff.valid <= 1'b0;
      end else if (advance) begin
         a_ff.valid <= a_in.valid;
         b_ff.valid <= a_ff.valid;
      end
      if (advance) begin
         a_ff.func     <= a_in.func;
         a_ff.hit      <= a_in.hit;
         a_ff.in_store <= a_in.in_store;
         a_ff.pixel    <= a_in.pixel;
         a_dx_ff       <= diff_x[DIM_W-1:0];
         a_dy_ff       <= diff_y[DIM_W-1:0];
         a_addr_ff     <= ADDR_W'(req_data.cursor_addr);

         b_ff.func     <= a_ff.func;
         b_ff.hit      <= a_ff.hit;
         b_ff.in_store <= a_ff.in_store;
         b_ff.pixel    <= a_ff.pixel;
         b_addr_ff     <= (a_ff.func == coab_pkg::FUNC_BLEND) ? idx_full[ADDR_W-1:0]
                                                              : a_addr_ff;
      end
   end

   assign op_stage = b_ff;
   assign op_addr  = b_addr_ff;

endmodule

>>> design/coab_store.sv
// ----------------------------------------------------------------------------
// coab_store
// Cursor word memory: loads write, covered blend beats read, in beat order.
// ----------------------------------------------------------------------------
module coab_store #(
   parameter int MAX_CURSOR_DIM = 64,
   localparam int DEPTH  = MAX_CURSOR_DIM * MAX_CURSOR_DIM,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  coab_pkg::stage_type op_stage,
   input  logic [ADDR_W-1:0]   op_addr,
   output coab_pkg::stage_type rd_stage,
   output logic [31:0]         rd_word
);

   logic [31:0]         mem [DEPTH];
   logic [31:0]         rd_word_ff;
   coab_pkg::stage_type rd_stage_ff;
   logic                wr_en, rd_en;

   // loads and reads share one stage, so a later read sees an earlier load
   assign wr_en = advance && op_stage.valid && op_stage.in_store &&
                  (op_stage.func == coab_pkg::FUNC_LOAD);
   assign rd_en = advance && op_stage.valid && op_stage.hit &&
                  (op_stage.func == coab_pkg::FUNC_BLEND);

   // memory port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[op_addr] <= op_stage.pixel;
      end
      if (rd_en) begin
         rd_word_ff <= mem[op_addr];
      end
   end

   // beat control alongside the read data; only valid takes reset
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_stage_ff.valid <= 1'b0;
      end else if (advance) begin
         rd_stage_ff.valid <= op_stage.valid;
      end
      if (advance) begin
         rd_stage_ff.func     <= op_stage.func;
         rd_stage_ff.hit      <= op_stage.hit;
         rd_stage_ff.in_store <= op_stage.in_store;
         rd_stage_ff.pixel    <= op_stage.pixel;
      end
   end

   assign rd_stage = rd_stage_ff;
   assign rd_word  = rd_word_ff;

endmodule

>>> design/coab_blend.sv
// ----------------------------------------------------------------------------
// coab_blend
// Premultiplied alpha blend and the result register.
// ----------------------------------------------------------------------------
module coab_blend (
   input  logic                clock,
   input  logic                reset,
   input  coab_pkg::stage_type rd_stage,
   input  logic [31:0]         rd_word,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output coab_pkg::rsp_type   rsp_data,
   output logic                advance
);

   logic              out_valid_ff;
   coab_pkg::rsp_type out_data_ff, out_data_in;
   logic [7:0]        alpha, inv_alpha;
   logic [31:0]       mixed;

   // pipeline moves unless a finished result is held
   assign advance = !out_valid_ff || !rsp_stall;

   // per channel: cursor + round(frame * (255 - a) / 255), divide by 255
   // done as (x + 1 + (x >> 8)) >> 8, exact over this range
   always_comb begin
      logic [15:0] prod;
      logic [16:0] quo;
      alpha     = rd_word[coab_pkg::ALPHA_SHIFT +: 8];
      inv_alpha = coab_pkg::FULL_ALPHA - alpha;
      mixed     = {rd_stage.pixel[31:24], 24'd0};
      for (int i = 0; i < 3; i++) begin
         prod = 16'(rd_stage.pixel[8*i +: 8]) * 16'(inv_alpha) + coab_pkg::HALF_ROUND;
         quo  = (17'(prod) + 17'd1 + 17'(prod[15:8])) >> 8;
         mixed[8*i +: 8] = rd_word[8*i +: 8] + quo[7:0];
      end
      if (alpha == coab_pkg::FULL_ALPHA) begin
         mixed = rd_word;
      end
      out_data_in.covered   = rd_stage.hit;
      out_data_in.pixel_out = rd_stage.hit ? mixed : rd_stage.pixel;
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= rd_stage.valid && (rd_stage.func == coab_pkg::FUNC_BLEND);
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

>>> design/coab_checker.sv
// ----------------------------------------------------------------------------
// coab_checker
// Port-level checks for the cursor overlay, bound to the top level.
// ----------------------------------------------------------------------------
`include "cursor_overlay_alpha_blend_macros.svh"

module coab_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input coab_pkg::rsp_type rsp_data,
   input logic              csr_valid,
   input logic              csr_ready
);

   // held result beat keeps its payload
   `COAB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // no result straight out of reset
   `COAB_ASSERT_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_valid)

   // a register write holds off requests for the next cycle
   `COAB_ASSERT_NEXT(a_csr_holdoff, clock, reset, csr_valid && csr_ready, req_stall)

   // a held result freezes the whole pipeline, so requests wait too
   `COAB_ASSERT_IMPL(a_backpressure, clock, reset, rsp_valid && rsp_stall, req_stall)

endmodule

bind cursor_overlay_alpha_blend coab_checker u_coab_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);
